// File: rtl/core/hllru_pkg.sv
// hllru_pkg: beat types and fixed field widths for the hyperloglog register update block
// no dependencies; imported by every module under rtl/core
package hllru_pkg;

  localparam int unsigned HashW  = 64;
  localparam int unsigned IndexW = 10;
  localparam int unsigned ValueW = 6;
  localparam int unsigned ZeroW  = 11;
  localparam int unsigned LzW    = 7;

  typedef enum logic {
    OP_OFFER = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef struct packed {
    op_e               operation;
    logic [HashW-1:0]  hash_value;
    logic [IndexW-1:0] register_index;
  } in_item_t;

  typedef struct packed {
    logic              changed;
    logic [ValueW-1:0] register_value;
    logic [HashW-1:0]  items_seen;
    logic [ZeroW-1:0]  zero_registers;
  } out_item_t;

endpackage

// File: rtl/core/hllru_rank.sv
// hllru_rank: splits a hash into register index and rank (leading zeros plus one)
// depends on hllru_pkg
module hllru_rank #(
  parameter int unsigned INDEX_BITS = 10
) (
  input  logic [hllru_pkg::HashW-1:0]  hash_i,
  output logic [INDEX_BITS-1:0]        index_o,
  output logic [hllru_pkg::ValueW-1:0] rank_o
);
  import hllru_pkg::*;

  localparam int unsigned RemBits = HashW - INDEX_BITS;

  logic [HashW-1:0] rem_aligned;
  logic [7:0]       byte_nz;
  logic [2:0]       byte_lz [8];
  logic [LzW-1:0]   lz;
  logic [LzW-1:0]   lz_inc;

  assign index_o     = hash_i[HashW-1 -: INDEX_BITS];
  assign rem_aligned = hash_i << INDEX_BITS;

  // per-byte leading zeros, then first nonzero byte from the top
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      byte_nz[b] = |rem_aligned[HashW-1-8*b -: 8];
      byte_lz[b] = 3'd0;
      for (int k = 0; k < 8; k++) begin
        if (rem_aligned[HashW-8-8*b+k]) begin
          byte_lz[b] = 3'(7 - k);
        end
      end
    end
    lz = LzW'(HashW);
    for (int b = 7; b >= 0; b--) begin
      if (byte_nz[b]) begin
        lz = LzW'(8 * b) + {4'd0, byte_lz[b]};
      end
    end
  end

  assign lz_inc = lz + LzW'(1);
  assign rank_o = (lz >= LzW'(RemBits)) ? ValueW'(RemBits + 1) : lz_inc[ValueW-1:0];

endmodule

// File: rtl/core/hllru_store.sv
// hllru_store: rank memory with registered read and a clearing pass after reset
// depends on hllru_pkg
module hllru_store #(
  parameter int unsigned INDEX_BITS = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [INDEX_BITS-1:0]        rd_addr_i,
  output logic [hllru_pkg::ValueW-1:0] rd_data_o,
  input  logic                         wr_en_i,
  input  logic [INDEX_BITS-1:0]        wr_addr_i,
  input  logic [hllru_pkg::ValueW-1:0] wr_data_i,
  output logic                         busy_o
);
  import hllru_pkg::*;

  localparam int unsigned Depth = 2 ** INDEX_BITS;

  logic [ValueW-1:0]     mem [Depth];
  logic [ValueW-1:0]     rd_data_q;
  logic                  clr_q, clr_d;
  logic [INDEX_BITS-1:0] clr_addr_q, clr_addr_d;
  logic                  mem_we;
  logic [INDEX_BITS-1:0] mem_waddr;
  logic [ValueW-1:0]     mem_wdata;

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + INDEX_BITS'(1);
      if (&clr_addr_q) begin
        clr_d = 1'b0;
      end
    end
  end

  assign mem_we    = clr_q | wr_en_i;
  assign mem_waddr = clr_q ? clr_addr_q : wr_addr_i;
  assign mem_wdata = clr_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_q;

endmodule

// File: rtl/core/hyperloglog_register_update.sv
// hyperloglog_register_update: top level, read-modify-write pipeline around the rank memory
// depends on hllru_pkg, hllru_rank, hllru_store
//
// Keeps 2^INDEX_BITS HyperLogLog registers in one synchronous memory. An offer beat raises
// the register picked by the top hash bits to the hash rank; a read beat returns one register.
// Every result carries the offer count and the number of registers still at zero. One beat is
// taken per cycle when the output side keeps up; a beat goes through the memory read, then the
// modify and write-back into the output register, with the value just written forwarded to a
// following beat on the same register. After reset the block clears the memory one entry
// per cycle, all 2^INDEX_BITS entries (1024 by default), and stalls its input until that
// pass ends.
module hyperloglog_register_update #(
  parameter int unsigned INDEX_BITS = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  hllru_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output hllru_pkg::out_item_t out_item_o
);
  import hllru_pkg::*;

  localparam int unsigned CntW  = INDEX_BITS + 1;
  localparam int unsigned ZExtW = (CntW > ZeroW) ? CntW : ZeroW;
  localparam int unsigned RExtW = (INDEX_BITS > IndexW) ? INDEX_BITS : IndexW;

  logic                  accept, adv, busy;
  logic [INDEX_BITS-1:0] offer_idx, in_addr;
  logic [ValueW-1:0]     offer_rank;
  logic [RExtW-1:0]      ridx_ext;

  logic                  s1_valid_q, s1_valid_d;
  op_e                   s1_op_q;
  logic [INDEX_BITS-1:0] s1_addr_q;
  logic [ValueW-1:0]     s1_rank_q;

  logic                  fwd_valid_q;
  logic [INDEX_BITS-1:0] fwd_addr_q;
  logic [ValueW-1:0]     fwd_data_q;

  logic [ValueW-1:0]     rd_data, cur, new_val;
  logic                  raise, wr_en;

  logic [HashW-1:0]      items_q, items_d;
  logic [CntW-1:0]       zero_q, zero_d;
  logic [ZExtW-1:0]      zero_ext;

  logic                  out_valid_q, out_valid_d;
  out_item_t             out_item_q;

  hllru_rank #(
    .INDEX_BITS(INDEX_BITS)
  ) u_rank (
    .hash_i (in_item_i.hash_value),
    .index_o(offer_idx),
    .rank_o (offer_rank)
  );

  assign ridx_ext = RExtW'(in_item_i.register_index);
  assign in_addr  = (in_item_i.operation == OP_READ) ? ridx_ext[INDEX_BITS-1:0] : offer_idx;

  assign adv        = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = busy | (s1_valid_q & ~adv);
  assign accept     = in_valid_i & ~in_stall_o;

  hllru_store #(
    .INDEX_BITS(INDEX_BITS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_addr_i(in_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(s1_addr_q),
    .wr_data_i(new_val),
    .busy_o   (busy)
  );

  // last write forwarded over the read-before-write memory
  assign cur     = (fwd_valid_q && fwd_addr_q == s1_addr_q) ? fwd_data_q : rd_data;
  assign raise   = (s1_op_q == OP_OFFER) && (s1_rank_q > cur);
  assign new_val = raise ? s1_rank_q : cur;
  assign wr_en   = adv & raise;

  always_comb begin
    items_d = items_q;
    zero_d  = zero_q;
    if (s1_op_q == OP_OFFER) begin
      items_d = items_q + HashW'(1);
    end
    if (raise && cur == '0 && zero_q != '0) begin
      zero_d = zero_q - CntW'(1);
    end
  end

  assign zero_ext = ZExtW'(zero_d);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_valid_q <= 1'b0;
      items_q     <= '0;
      zero_q      <= CntW'(1) << INDEX_BITS;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (wr_en) begin
        fwd_valid_q <= 1'b1;
      end
      if (adv) begin
        items_q <= items_d;
        zero_q  <= zero_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q   <= in_item_i.operation;
      s1_addr_q <= in_addr;
      s1_rank_q <= offer_rank;
    end
    if (wr_en) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= new_val;
    end
    if (adv) begin
      out_item_q.changed        <= raise;
      out_item_q.register_value <= new_val;
      out_item_q.items_seen     <= items_d;
      out_item_q.zero_registers <= zero_ext[ZeroW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: tb/tb_hyperloglog_register_update.sv
// tb_hyperloglog_register_update: self-checking bench for the hyperloglog register update block
// drives offer and read beats with random gaps and output stalls, checks against its own
// register array model; depends on hllru_pkg and hyperloglog_register_update
module tb_hyperloglog_register_update;
  import hllru_pkg::*;

  localparam int unsigned RemW        = HashW - IndexW;
  localparam int unsigned RegCount    = 1 << IndexW;
  localparam int unsigned RandomBeats = 500;
  localparam int unsigned CycleLimit  = 200000;

  typedef struct {
    in_item_t  beat;
    bit        typed;
    out_item_t want;
  } directed_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  logic [ValueW-1:0] rank_regs [RegCount];
  logic [HashW-1:0]  offers_taken;
  logic [ZeroW-1:0]  zero_regs_left;

  out_item_t     pending_results [$];
  out_item_t     oldest_pending;
  directed_row_t directed_rows [$];
  logic [IndexW-1:0] hot_regs [8];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned rx_hold        = 0;
  bit          quiet_stretch  = 1'b0;

  hyperloglog_register_update #(
    .INDEX_BITS(IndexW)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  function automatic int unsigned draw_wait();
    return quiet_stretch ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic out_item_t update_registers(input in_item_t beat);
    out_item_t         res;
    logic [IndexW-1:0] sel;
    logic [RemW-1:0]   rem;
    logic [ValueW-1:0] rank;
    res  = '0;
    if (beat.operation == OP_OFFER) begin
      sel  = beat.hash_value[HashW-1 -: IndexW];
      rem  = beat.hash_value[RemW-1:0];
      rank = ValueW'(RemW + 1);
      for (int b = RemW - 1; b >= 0; b--) begin
        if (rem[b]) begin
          rank = ValueW'(RemW - b);
          break;
        end
      end
      offers_taken = offers_taken + 1;
      if (rank_regs[sel] < rank) begin
        if (rank_regs[sel] == 0 && zero_regs_left != 0) zero_regs_left = zero_regs_left - 1'b1;
        rank_regs[sel] = rank;
        res.changed    = 1'b1;
      end
    end else begin
      sel = beat.register_index;
    end
    res.register_value = rank_regs[sel];
    res.items_seen     = offers_taken;
    res.zero_registers = zero_regs_left;
    return res;
  endfunction

  // rank 1..RemW puts the first one at that position, anything above gives an all-zero remainder
  function automatic logic [HashW-1:0] shape_hash(input logic [IndexW-1:0] idx,
                                                  input int unsigned rank,
                                                  input logic [HashW-1:0] noise);
    logic [RemW-1:0] rem;
    logic [RemW-1:0] unit;
    unit = RemW'(1);
    rem  = noise[RemW-1:0];
    if (rank > RemW) begin
      rem = '0;
    end else begin
      rem = rem & ((unit << (RemW - rank)) - 1);
      rem[RemW-rank] = 1'b1;
    end
    return {idx, rem};
  endfunction

  function automatic in_item_t offer_beat(input logic [HashW-1:0] hash,
                                          input logic [IndexW-1:0] idx);
    return '{OP_OFFER, hash, idx};
  endfunction

  function automatic in_item_t read_beat(input logic [IndexW-1:0] idx,
                                         input logic [HashW-1:0] hash);
    return '{OP_READ, hash, idx};
  endfunction

  task automatic add_row(input in_item_t beat, input bit typed, input out_item_t want);
    directed_rows.push_back('{beat, typed, want});
  endtask

  task automatic report_mismatch(input string what, input logic [HashW-1:0] got,
                                 input logic [HashW-1:0] want);
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_beat(input in_item_t beat, input bit typed, input out_item_t want);
    int unsigned gap;
    out_item_t   predicted;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= beat;
    do @(posedge clk_i); while (in_stall_o);
    predicted = update_registers(beat);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending, items_seen",
                        out_item_o.items_seen, 0);
      end else begin
        oldest_pending = pending_results.pop_front();
        if (out_item_o.changed !== oldest_pending.changed)
          report_mismatch("changed", out_item_o.changed, oldest_pending.changed);
        if (out_item_o.register_value !== oldest_pending.register_value)
          report_mismatch("register_value", out_item_o.register_value,
                          oldest_pending.register_value);
        if (out_item_o.items_seen !== oldest_pending.items_seen)
          report_mismatch("items_seen", out_item_o.items_seen, oldest_pending.items_seen);
        if (out_item_o.zero_registers !== oldest_pending.zero_registers)
          report_mismatch("zero_registers", out_item_o.zero_registers,
                          oldest_pending.zero_registers);
      end
      rx_hold <= draw_wait();
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end
  end

  always @(negedge clk_i) out_stall_i <= (rx_hold != 0);

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("FAIL hyperloglog_register_update");
    $finish;
  end

  initial begin
    in_item_t          beat;
    logic [IndexW-1:0] idx;
    logic [IndexW-1:0] last_offered;
    int unsigned       pick;
    int unsigned       rank;

    for (int i = 0; i < RegCount; i++) rank_regs[i] = '0;
    offers_taken   = '0;
    zero_regs_left = ZeroW'(RegCount);
    last_offered   = '0;
    for (int i = 0; i < 8; i++) hot_regs[i] = IndexW'($urandom);

    // after reset, extremes of the hash, equal and lower ranks, forwarding on one register
    add_row(read_beat(10'd0, 64'd0), 1'b1, '{1'b0, 6'd0, 64'd0, 11'd1024});
    add_row(read_beat(10'h3FF, '1), 1'b1, '{1'b0, 6'd0, 64'd0, 11'd1024});
    add_row(offer_beat(64'd0, 10'd0), 1'b1, '{1'b1, 6'd55, 64'd1, 11'd1023});
    add_row(offer_beat('1, '1), 1'b1, '{1'b1, 6'd1, 64'd2, 11'd1022});
    add_row(offer_beat(64'hFFC0_0000_0000_0000, 10'd0), 1'b1,
            '{1'b1, 6'd55, 64'd3, 11'd1022});
    add_row(offer_beat('1, 10'd0), 1'b1, '{1'b0, 6'd55, 64'd4, 11'd1022});
    add_row(read_beat(10'h3FF, 64'd0), 1'b1, '{1'b0, 6'd55, 64'd4, 11'd1022});
    add_row(offer_beat(shape_hash(10'd5, 1, '1), '1), 1'b0, '0);
    add_row(offer_beat(shape_hash(10'd5, 54, '1), 10'd0), 1'b0, '0);
    add_row(offer_beat(shape_hash(10'd5, 54, 64'd0), 10'd0), 1'b0, '0);
    add_row(offer_beat(shape_hash(10'd5, 20, '1), 10'd0), 1'b0, '0);
    add_row(read_beat(10'd5, '1), 1'b0, '0);
    add_row(offer_beat(shape_hash(10'd512, 2, 64'h5555_5555_5555_5555), 10'h155), 1'b0, '0);
    add_row(offer_beat(shape_hash(10'd512, 3, 64'hAAAA_AAAA_AAAA_AAAA), 10'h2AA), 1'b0, '0);
    add_row(read_beat(10'd512, 64'h5555_5555_5555_5555), 1'b0, '0);
    add_row(offer_beat(shape_hash(10'd512, 55, '1), 10'd0), 1'b0, '0);
    add_row(offer_beat(shape_hash(10'd1, 8, 64'd0), 10'd0), 1'b0, '0);
    add_row(read_beat(10'd0, '1), 1'b0, '0);
    add_row(read_beat(10'd1, 64'd0), 1'b0, '0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    quiet_stretch = 1'b1;
    foreach (directed_rows[r]) begin
      if (r == 12) quiet_stretch = 1'b0;
      send_beat(directed_rows[r].beat, directed_rows[r].typed, directed_rows[r].want);
    end

    for (int n = 0; n < RandomBeats; n++) begin
      if (n % 32 == 0) quiet_stretch = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        case ($urandom_range(0, 2))
          0:       idx = hot_regs[$urandom_range(0, 7)];
          1:       idx = last_offered;
          default: idx = IndexW'($urandom);
        endcase
        beat = read_beat(idx, {$urandom, $urandom});
      end else if (pick == 2) begin
        beat = offer_beat({$urandom, $urandom}, IndexW'($urandom));
        last_offered = beat.hash_value[HashW-1 -: IndexW];
      end else begin
        idx  = $urandom_range(0, 1) ? hot_regs[$urandom_range(0, 7)] : IndexW'($urandom);
        rank = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(1, RemW + 1);
        beat = offer_beat(shape_hash(idx, rank, {$urandom, $urandom}), IndexW'($urandom));
        last_offered = idx;
      end
      send_beat(beat, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS hyperloglog_register_update");
    end else begin
      $display("FAIL hyperloglog_register_update");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/hllru_pkg.sv
rtl/core/hllru_rank.sv
rtl/core/hllru_store.sv
rtl/core/hyperloglog_register_update.sv
tb/tb_hyperloglog_register_update.sv
